// ----- hdl/ckc_pkg.sv -----
// Package: shared types, constants and keyword table for the C keyword counter.
`timescale 1ns / 1ps
package ckc_pkg;

  localparam int NUM_KEYWORDS_DEF = 32;
  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int MAX_LETTERS      = 8;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  keyword_index;
    logic [31:0] keyword_count;
    logic        last_of_dump;
  } out_req_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       take_byte;
    logic       close_run;
    logic       clear_idx;
    logic       step_idx;
    logic       load_out;
  } ckc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last_idx;
  } ckc_sts_t;

  localparam logic [3:0] MODE_CODE          = 4'd0;
  localparam logic [3:0] MODE_LINE_START    = 4'd1;
  localparam logic [3:0] MODE_SLASH         = 4'd2;
  localparam logic [3:0] MODE_STAR          = 4'd3;
  localparam logic [3:0] MODE_LINE_COMMENT  = 4'd4;
  localparam logic [3:0] MODE_BLOCK_COMMENT = 4'd5;
  localparam logic [3:0] MODE_SQUOTE        = 4'd6;
  localparam logic [3:0] MODE_DQUOTE        = 4'd7;
  localparam logic [3:0] MODE_ESCAPE        = 4'd8;
  localparam logic [3:0] MODE_PREPROC       = 4'd9;

  localparam logic [1:0] RUN_NONE     = 2'd0;
  localparam logic [1:0] RUN_LETTERS  = 2'd1;
  localparam logic [1:0] RUN_REJECTED = 2'd2;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // Keywords packed little-endian: first letter in bits 7:0.
  function automatic logic [63:0] kw_word(input logic [4:0] k);
    logic [63:0] w;
    unique case (k)
      5'd0:  w = 64'h6F747561;
      5'd1:  w = 64'h6B61657262;
      5'd2:  w = 64'h65736163;
      5'd3:  w = 64'h72616863;
      5'd4:  w = 64'h74736E6F63;
      5'd5:  w = 64'h65756E69746E6F63;
      5'd6:  w = 64'h746C7561666564;
      5'd7:  w = 64'h6F64;
      5'd8:  w = 64'h656C62756F64;
      5'd9:  w = 64'h65736C65;
      5'd10: w = 64'h6D756E65;
      5'd11: w = 64'h6E7265747865;
      5'd12: w = 64'h74616F6C66;
      5'd13: w = 64'h726F66;
      5'd14: w = 64'h6F746F67;
      5'd15: w = 64'h6669;
      5'd16: w = 64'h746E69;
      5'd17: w = 64'h676E6F6C;
      5'd18: w = 64'h7265747369676572;
      5'd19: w = 64'h6E7275746572;
      5'd20: w = 64'h74726F6873;
      5'd21: w = 64'h64656E676973;
      5'd22: w = 64'h666F657A6973;
      5'd23: w = 64'h636974617473;
      5'd24: w = 64'h746375727473;
      5'd25: w = 64'h686374697773;
      5'd26: w = 64'h66656465707974;
      5'd27: w = 64'h6E6F696E75;
      5'd28: w = 64'h64656E6769736E75;
      5'd29: w = 64'h64696F76;
      5'd30: w = 64'h656C6974616C6F76;
      default: w = 64'h656C696877;
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/ckc_datapath.sv -----
// Datapath: lexer mode, identifier run, keyword match and count registers.
`timescale 1ns / 1ps
module ckc_datapath import ckc_pkg::*; #(
  parameter int NUM_KEYWORDS = NUM_KEYWORDS_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] byte_i,
  input  ckc_cmd_t   cmd,
  output ckc_sts_t   sts,
  output out_req_t   out_d
);

  localparam logic [4:0] LAST_IDX = 5'(NUM_KEYWORDS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [3:0]  mode_r, mode_nxt, esc_r, esc_nxt;
  logic [63:0] letters_r, letters_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [1:0]  run_r, run_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r [NUM_KEYWORDS];
  logic [4:0]  idx_r;
  logic        pass, letter, word, sp, is_code, close;
  logic        hit [NUM_KEYWORDS];

  always_comb begin
    is_code  = (mode_r == MODE_CODE) || (mode_r == MODE_LINE_START);
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    pass     = 1'b0;
    sp = (byte_i == 8'h20) || (byte_i == 8'h09) || (byte_i == 8'h0B) ||
         (byte_i == 8'h0C) || (byte_i == 8'h0D);
    unique case (byte_i)
      CH_DQUOTE: begin
        if (is_code) mode_nxt = MODE_DQUOTE;
        else if (mode_r == MODE_DQUOTE) mode_nxt = MODE_CODE;
        else if (mode_r == MODE_ESCAPE) mode_nxt = esc_r;
      end
      CH_SQUOTE: begin
        if (is_code) mode_nxt = MODE_SQUOTE;
        else if (mode_r == MODE_SQUOTE) mode_nxt = MODE_CODE;
        else if (mode_r == MODE_ESCAPE) mode_nxt = esc_r;
      end
      CH_BSLASH: begin
        if (mode_r == MODE_ESCAPE) mode_nxt = esc_r;
        else if (mode_r != MODE_LINE_COMMENT && mode_r != MODE_BLOCK_COMMENT) begin
          esc_nxt  = mode_r;
          mode_nxt = MODE_ESCAPE;
        end
      end
      CH_SLASH: begin
        if (is_code) mode_nxt = MODE_SLASH;
        else if (mode_r == MODE_SLASH) mode_nxt = MODE_LINE_COMMENT;
        else if (mode_r == MODE_STAR) mode_nxt = MODE_CODE;
        else if (mode_r == MODE_ESCAPE) mode_nxt = esc_r;
      end
      CH_STAR: begin
        if (mode_r == MODE_SLASH) mode_nxt = MODE_BLOCK_COMMENT;
        else if (mode_r == MODE_BLOCK_COMMENT) mode_nxt = MODE_STAR;
        else if (mode_r == MODE_ESCAPE) mode_nxt = esc_r;
        else pass = is_code;
      end
      CH_HASH: begin
        if (mode_r == MODE_LINE_START) mode_nxt = MODE_PREPROC;
      end
      CH_NL: begin
        if (mode_r == MODE_ESCAPE) mode_nxt = esc_r;
        else if (mode_r != MODE_BLOCK_COMMENT) begin
          mode_nxt = MODE_LINE_START;
          pass     = 1'b1;
        end
      end
      default: begin
        if (mode_r == MODE_STAR) mode_nxt = MODE_BLOCK_COMMENT;
        else if (mode_r == MODE_SLASH) mode_nxt = MODE_CODE;
        else if (mode_r == MODE_ESCAPE) mode_nxt = esc_r;
        else if (is_code) begin
          pass = 1'b1;
          if (mode_r == MODE_LINE_START && !sp) mode_nxt = MODE_CODE;
        end
      end
    endcase
  end

  always_comb begin
    letter = ((byte_i >= 8'h61) && (byte_i <= 8'h7A)) ||
             ((byte_i >= 8'h41) && (byte_i <= 8'h5A));
    word   = letter || ((byte_i >= 8'h30) && (byte_i <= 8'h39)) || (byte_i == CH_UNDER);
    close  = cmd.close_run || (cmd.take_byte && pass && !word);
    letters_nxt = letters_r;
    len_nxt     = len_r;
    run_nxt     = run_r;
    if (close) begin
      letters_nxt = '0;
      len_nxt     = '0;
      run_nxt     = RUN_NONE;
    end else if (cmd.take_byte && pass) begin
      if (run_r == RUN_NONE) run_nxt = letter ? RUN_LETTERS : RUN_REJECTED;
      else if (run_r == RUN_LETTERS && !letter) run_nxt = RUN_REJECTED;
      if (run_nxt == RUN_LETTERS) begin
        if (len_r < 4'(MAX_LETTERS)) begin
          letters_nxt = letters_r | (64'(byte_i) << {len_r[2:0], 3'b000});
          len_nxt     = len_r + 4'd1;
        end else begin
          run_nxt = RUN_REJECTED;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++)
      hit[k] = (run_r == RUN_LETTERS) && (letters_r == kw_word(5'(k)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_LINE_START;
      esc_r     <= MODE_LINE_START;
      letters_r <= '0;
      len_r     <= '0;
      run_r     <= RUN_NONE;
      idx_r     <= '0;
      for (int k = 0; k < NUM_KEYWORDS; k++) cnt_r[k] <= '0;
    end else begin
      if (cmd.take_byte) begin
        mode_r <= mode_nxt;
        esc_r  <= esc_nxt;
      end
      letters_r <= letters_nxt;
      len_r     <= len_nxt;
      run_r     <= run_nxt;
      if (close) begin
        for (int k = 0; k < NUM_KEYWORDS; k++)
          if (hit[k] && cnt_r[k] != CNT_MAX) cnt_r[k] <= cnt_r[k] + 1'b1;
      end
      if (cmd.clear_idx) idx_r <= '0;
      else if (cmd.step_idx) idx_r <= idx_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_d.keyword_index <= idx_r;
      out_d.keyword_count <= 32'(cnt_r[idx_r]);
      out_d.last_of_dump  <= (idx_r == LAST_IDX);
    end
  end

  assign sts.last_idx = (idx_r == LAST_IDX);

endmodule

// ----- hdl/ckc_ctrl.sv -----
// Controller: accepts bytes, sequences the end-of-input dump.
`timescale 1ns / 1ps
module ckc_ctrl import ckc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_eoi,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  input  ckc_sts_t sts,
  output ckc_cmd_t cmd
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_DUMP  = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;
  logic       acc, slot;

  always_comb begin
    in_stall = (st_r != ST_RUN);
    acc      = in_valid && !in_stall;
    slot     = !ov_r || !out_stall;
    cmd      = '0;
    st_nxt   = st_r;
    ov_nxt   = ov_r && out_stall;
    unique case (st_r)
      ST_RUN: begin
        if (acc && in_eoi) begin
          cmd.close_run = 1'b1;
          cmd.clear_idx = 1'b1;
          st_nxt        = ST_CLOSE;
        end else if (acc) begin
          cmd.take_byte = 1'b1;
        end
      end
      ST_CLOSE: st_nxt = ST_DUMP;   // counts settle after closing the run
      ST_DUMP: begin
        if (slot) begin
          cmd.load_out = 1'b1;
          ov_nxt       = 1'b1;
          if (sts.last_idx) st_nxt = ST_RUN;
          else cmd.step_idx = 1'b1;
        end
      end
      default: st_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RUN;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule

// ----- hdl/c_keyword_counter_unit.sv -----
// Top level of the C keyword counter.
// Input channel: one request per cycle (unless in_stall) carries a source
// byte or an end-of-input mark. Bytes are taken one per cycle, no result.
// An end-of-input request closes the pending identifier run and then
// dumps NUM_KEYWORDS results (index, saturating count, last flag),
// one per cycle unless out_stall holds them; the output register keeps
// a stalled result steady. After the end-of-input request the controller
// passes ST_CLOSE, then loads the first result into the output register
// in ST_DUMP; in_stall is high in both states, while the dump sequencer
// walks the count registers one per cycle unless out_stall holds it.
// Reset (rst_n low, synchronous) puts the lexer in line-start mode,
// drops any open run and clears every count. Counts and lexer mode
// persist across dumps.
`timescale 1ns / 1ps
module c_keyword_counter_unit import ckc_pkg::*; #(
  parameter int NUM_KEYWORDS = NUM_KEYWORDS_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  ckc_cmd_t cmd;
  ckc_sts_t sts;

  ckc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_eoi(in_data.end_of_input), .in_stall,
    .out_stall, .out_valid, .sts, .cmd
  );

  ckc_datapath #(.NUM_KEYWORDS(NUM_KEYWORDS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk, .rst_n, .byte_i(in_data.source_byte), .cmd, .sts, .out_d(out_data)
  );

endmodule
